FILE: rtl/core/dgt_pkg.sv
package dgt_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_WIDTH     = 2'd1;
  localparam logic [1:0] CFG_HEIGHT    = 2'd2;

  localparam logic [15:0] THRESHOLD_RESET = 16'd5;
  localparam logic [10:0] WIDTH_RESET     = 11'd640;
  localparam logic [10:0] HEIGHT_RESET    = 11'd480;

  // wide enough for any clamped frame size
  localparam int SIZE_W = 13;

  localparam int IDX_W = 20;

  // output queue
  localparam int OUT_DEPTH = 4;
  localparam int OUT_PTR_W = 2;
  localparam int OUT_CNT_W = 3;

  // triangle kinds
  localparam logic KIND_LEFT  = 1'b0;
  localparam logic KIND_ABOVE = 1'b1;

  typedef struct packed {
    logic             valid;
    logic [15:0]      depth;
    logic             col_nz;
    logic             row_nz;
    logic [IDX_W-1:0] idx;
  } pix_stage_t;

  typedef struct packed {
    logic [IDX_W-1:0] first;
    logic [IDX_W-1:0] centre;
    logic [IDX_W-1:0] diag;
    logic             kind;
    logic             last;
  } tri_t;

  function automatic logic near_enough(input logic [15:0] a, input logic [15:0] b,
                                       input logic [15:0] thr);
    logic [15:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return d < thr;
  endfunction

endpackage

FILE: rtl/core/depth_grid_triangulator.sv
// grid triangulation of a depth image streamed one pixel per word
//
// s_*  : pixels in row-major order; tdata = depth in mm, tuser = frame start
// m_*  : triangles as three linear pixel indices; tuser = triangle kind,
//        tlast = last triangle of its pixel
// cfg_*: register writes (threshold, frame width, frame height), always ready
//
// one pixel can be taken every cycle while the output queue has room; the
// line buffer is read when the pixel is taken and written in the cycle after,
// so the memory port pair sets that rate. a pixel that yields two triangles
// pushes both into the queue together, while the output side moves one
// triangle per cycle when the receiver is ready. a triangle is registered in
// the second pixel stage and then in the output queue before it is offered.
// a four-word output queue lets pixels keep flowing while the receiver
// stalls; s_tready drops only when the queue could not hold the next results.
// reset clears counters, neighbours and the queue and loads the default
// registers; the line buffer is not cleared, the first row fills it.
module depth_grid_triangulator #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // depth_mm [15:0]
  input  logic [15:0] s_tdata,
  // frame_start [0]
  input  logic [0:0]  s_tuser,
  input  logic        s_tvalid,
  output logic        s_tready,
  // corner_first [19:0], corner_centre [39:20], corner_diag [59:40], zero [63:60]
  output logic [63:0] m_tdata,
  // triangle_kind [0]
  output logic [0:0]  m_tuser,
  output logic        m_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import dgt_pkg::*;

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int ROW_W = $clog2(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] MAX_W_S = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_S = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] MIN_S   = SIZE_W'(2);

  // configuration
  logic [15:0]       threshold;
  logic [10:0]       width_reg;
  logic [10:0]       height_reg;
  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;

  // position counters
  logic [COL_W-1:0]  col;
  logic [ROW_W-1:0]  row;
  logic [IDX_W-1:0]  idx;
  logic [COL_W-1:0]  col_cur;
  logic [ROW_W-1:0]  row_cur;
  logic [IDX_W-1:0]  idx_cur;
  logic [SIZE_W-1:0] col_inc;
  logic [SIZE_W-1:0] row_inc;

  // second stage and neighbours
  pix_stage_t        s1;
  logic [COL_W-1:0]  s1_addr;
  logic [15:0]       left_depth;
  logic [15:0]       diag_depth;
  logic [15:0]       above_depth;

  logic              accept;
  logic [1:0]        ev_count;
  tri_t              ev0;
  tri_t              ev1;
  logic [OUT_CNT_W-1:0] fill;
  tri_t              out_word;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RESET;
      width_reg  <= WIDTH_RESET;
      height_reg <= HEIGHT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold  <= cfg_data;
        CFG_WIDTH:     width_reg  <= cfg_data[10:0];
        CFG_HEIGHT:    height_reg <= cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // sizes clamped to the range the counters and line buffer support
  always_comb begin
    if (width_reg < 11'd2) begin
      width_eff = MIN_S;
    end else if (SIZE_W'(width_reg) > MAX_W_S) begin
      width_eff = MAX_W_S;
    end else begin
      width_eff = SIZE_W'(width_reg);
    end
    if (height_reg < 11'd2) begin
      height_eff = MIN_S;
    end else if (SIZE_W'(height_reg) > MAX_H_S) begin
      height_eff = MAX_H_S;
    end else begin
      height_eff = SIZE_W'(height_reg);
    end
  end

  // room for two results of this pixel on top of those of the pixel ahead
  assign s_tready = (fill + OUT_CNT_W'(ev_count)) <= OUT_CNT_W'(OUT_DEPTH - 2);
  assign accept   = s_tvalid && s_tready;

  // frame start zeroes the position before the pixel is used
  always_comb begin
    col_cur = s_tuser[0] ? '0 : col;
    row_cur = s_tuser[0] ? '0 : row;
    idx_cur = s_tuser[0] ? '0 : idx;
    col_inc = SIZE_W'(col_cur) + SIZE_W'(1);
    row_inc = SIZE_W'(row_cur) + SIZE_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      idx <= '0;
    end else if (accept) begin
      idx <= idx_cur + IDX_W'(1);
      if (col_inc >= width_eff) begin
        col <= '0;
        if (row_inc >= height_eff) begin
          row <= '0;
          idx <= '0;
        end else begin
          row <= row_inc[ROW_W-1:0];
        end
      end else begin
        col <= col_inc[COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0;
    end else begin
      s1.valid <= accept;
    end
    if (accept) begin
      s1.depth  <= s_tdata;
      s1.col_nz <= (col_cur != '0);
      s1.row_nz <= (row_cur != '0);
      s1.idx    <= idx_cur;
      s1_addr   <= col_cur;
    end
  end

  // read above neighbour at take, write the pixel back in the cycle after
  dgt_line_buf #(
    .DEPTH  (MAX_WIDTH),
    .ADDR_W (COL_W)
  ) u_line_buf (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .wr_en   (s1.valid),
    .wr_addr (s1_addr),
    .wr_data (s1.depth),
    .rd_data (above_depth)
  );

  dgt_tri_eval u_eval (
    .pix         (s1),
    .left_depth  (left_depth),
    .diag_depth  (diag_depth),
    .above_depth (above_depth),
    .threshold   (threshold),
    .width       (width_eff),
    .count       (ev_count),
    .first_tri   (ev0),
    .second_tri  (ev1)
  );

  // the above word of this pixel is the diagonal of the next one
  always_ff @(posedge clk) begin
    if (rst) begin
      left_depth <= '0;
      diag_depth <= '0;
    end else if (s1.valid) begin
      left_depth <= s1.depth;
      diag_depth <= above_depth;
    end
  end

  dgt_out_fifo u_out_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (ev_count),
    .push0      (ev0),
    .push1      (ev1),
    .fill       (fill),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_word   (out_word)
  );

  assign m_tdata    = {4'd0, out_word.diag, out_word.centre, out_word.first};
  assign m_tuser[0] = out_word.kind;
  assign m_tlast    = out_word.last;

  // a pair of triangles leaves as left-kind first, above-kind last
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (ev_count == 2'd2) |-> (!ev0.last && ev0.kind == KIND_LEFT &&
                            ev1.last && ev1.kind == KIND_ABOVE))
    else $error("triangle pair out of order");

  // after a push, the queue offers a word on the next cycle
  a_push_shows: assert property (@(posedge clk) disable iff (rst)
    (!rst && ev_count != 2'd0) |=> m_tvalid)
    else $error("pushed triangle not offered");

  // frame start yields a pixel at index zero in the first row and column
  a_frame_start: assert property (@(posedge clk) disable iff (rst)
    (!rst && accept && s_tuser[0]) |=> (s1.idx == '0 && !s1.col_nz && !s1.row_nz))
    else $error("frame start did not zero the position");

  // the queue never holds more than its depth
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (!rst && s1.valid) |-> (fill + OUT_CNT_W'(ev_count)) <= OUT_CNT_W'(OUT_DEPTH))
    else $error("output queue overflow");

endmodule

FILE: rtl/core/dgt_line_buf.sv
module dgt_line_buf #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [15:0]       wr_data,
  output logic [15:0]       rd_data
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rd_q;
  logic        byp;
  logic [15:0] byp_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q     <= mem[rd_addr];
      // same entry written in this cycle: hand on the new word
      byp      <= wr_en && (wr_addr == rd_addr);
      byp_data <= wr_data;
    end
  end

  assign rd_data = byp ? byp_data : rd_q;

endmodule

FILE: rtl/core/dgt_tri_eval.sv
module dgt_tri_eval (
  input  dgt_pkg::pix_stage_t           pix,
  input  logic [15:0]                   left_depth,
  input  logic [15:0]                   diag_depth,
  input  logic [15:0]                   above_depth,
  input  logic [15:0]                   threshold,
  input  logic [dgt_pkg::SIZE_W-1:0]    width,
  output logic [1:0]                    count,
  output dgt_pkg::tri_t                 first_tri,
  output dgt_pkg::tri_t                 second_tri
);
  import dgt_pkg::*;

  logic             base;
  logic             ok_left;
  logic             ok_above;
  logic [IDX_W-1:0] idx_up;
  logic [IDX_W-1:0] idx_diag;
  logic [IDX_W-1:0] idx_left;
  tri_t             t_left;
  tri_t             t_above;

  always_comb begin
    base = pix.valid && (pix.depth != 16'd0) && pix.col_nz && pix.row_nz &&
           near_enough(pix.depth, diag_depth, threshold);
    ok_left  = base && near_enough(pix.depth, left_depth, threshold) &&
               near_enough(left_depth, diag_depth, threshold);
    ok_above = base && near_enough(pix.depth, above_depth, threshold) &&
               near_enough(above_depth, diag_depth, threshold);

    idx_up   = pix.idx - IDX_W'(width);
    idx_diag = idx_up - IDX_W'(1);
    idx_left = pix.idx - IDX_W'(1);

    t_left  = '{first: idx_left, centre: pix.idx, diag: idx_diag,
                kind: KIND_LEFT, last: !ok_above};
    t_above = '{first: idx_up, centre: pix.idx, diag: idx_diag,
                kind: KIND_ABOVE, last: 1'b1};

    // packed so that the first word to leave is always in first_tri
    first_tri  = ok_left ? t_left : t_above;
    second_tri = t_above;
    count      = {1'b0, ok_left} + {1'b0, ok_above};
  end

endmodule

FILE: rtl/core/dgt_out_fifo.sv
module dgt_out_fifo (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [1:0]                    push_count,
  input  dgt_pkg::tri_t                 push0,
  input  dgt_pkg::tri_t                 push1,
  output logic [dgt_pkg::OUT_CNT_W-1:0] fill,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dgt_pkg::tri_t                 out_word
);
  import dgt_pkg::*;

  tri_t                 slots [OUT_DEPTH];
  logic [OUT_PTR_W-1:0] wr_ptr;
  logic [OUT_PTR_W-1:0] rd_ptr;
  logic                 pop;

  assign out_valid = (fill != '0);
  assign out_word  = slots[rd_ptr];
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + OUT_PTR_W'(1)] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + OUT_PTR_W'(push_count);
      if (pop) begin
        rd_ptr <= rd_ptr + OUT_PTR_W'(1);
      end
      fill <= fill + OUT_CNT_W'(push_count) - OUT_CNT_W'(pop);
    end
  end

endmodule

FILE: tb/tb_depth_grid_triangulator.sv
module tb_depth_grid_triangulator;
  import dgt_pkg::*;

  localparam int MAX_W = 1024;
  localparam int MAX_H = 1024;
  // generous ceiling on the whole run, in clock cycles
  localparam int unsigned CYCLE_LIMIT = 1000000;
  // cycles allowed after the last triangle for any word still in flight
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_PIXELS = 120;

  // one pixel word as the source side drives it
  typedef struct {
    logic [15:0] depth;
    logic        frame_start;
  } pixel_word_t;

  // hand-picked frame for the directed part, threshold 10, 4 x 3 pixels;
  // frame start on words 0 and 16 (the second one cuts a frame short)
  localparam logic [15:0] DIRECTED_DEPTHS [0:23] = '{
    // row 0
    16'd100, 16'd100, 16'd100, 16'd100,
    // row 1: two pixels with both triangles, then a far diagonal
    16'd100, 16'd105, 16'd100, 16'd200,
    // row 2: zero pixel, far diagonal, above-only triangle, far diagonal
    16'd0, 16'd3, 16'd103, 16'd195,
    // next frame by wrap-around, first row only
    16'd0, 16'd0, 16'd65535, 16'd65535,
    // restarted frame: row 0 with zero and top-of-range depths
    16'd0, 16'd0, 16'd65535, 16'd65500,
    // row 1: both triangles against zero neighbours, far diagonal, left-only
    16'd5, 16'd4, 16'd65529, 16'd65535
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic [15:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        m_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  depth_grid_triangulator #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // words waiting for the source side, and triangles still owed by the block
  pixel_word_t pending_pixels[$];
  tri_t        expected_tris[$];

  // predictor's copy of the registers, at their reset values
  logic [15:0] thr_reg    = THRESHOLD_RESET;
  logic [10:0] width_reg  = WIDTH_RESET;
  logic [10:0] height_reg = HEIGHT_RESET;

  // predictor's copy of the image state; the line store reads as zero until
  // written, which only ever matters for values that are never used
  logic [15:0] row_above_mem [MAX_W];
  logic [15:0] left_px  = '0;
  logic [15:0] diag_px  = '0;
  int unsigned col_pos  = 0;
  int unsigned row_pos  = 0;
  logic [19:0] lin_idx  = '0;

  // idling controls, changed between phases
  bit          src_idle_on  = 1'b0;
  bit          sink_idle_on = 1'b0;
  int unsigned src_gap      = 0;
  int unsigned sink_stall   = 0;

  int unsigned bad_count = 0;
  int unsigned cycle_count = 0;

  initial begin
    foreach (row_above_mem[i]) row_above_mem[i] = '0;
  end

  function automatic int unsigned clamp_size(input logic [10:0] raw, input int unsigned top);
    if (raw < 11'd2) return 2;
    if (raw > top) return top;
    return raw;
  endfunction

  // two depths are close when their distance is strictly under the threshold
  function automatic bit depths_close(input logic [15:0] a, input logic [15:0] b);
    logic [15:0] delta;
    delta = (a > b) ? (a - b) : (b - a);
    return delta < thr_reg;
  endfunction

  // idle length: mostly short, now and then long
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // mostly near the phase's base depth, with the odd hole and the odd outlier
  function automatic logic [15:0] smooth_depth(input logic [15:0] base,
                                               input int unsigned spread);
    int unsigned v;
    int unsigned pick;
    pick = $urandom_range(0, 31);
    if (pick == 0) return '0;
    if (pick == 1) return 16'($urandom);
    v = int'(base) + $urandom_range(0, spread);
    return (v > 65535) ? 16'hFFFF : 16'(v);
  endfunction

  task automatic report_bad(input string msg);
    $display("%0t bad triangle: %s", $time, msg);
    bad_count++;
  endtask

  // one accepted pixel: advance the image state and queue the triangles it owes
  task automatic triangulate_pixel(input logic [15:0] depth, input logic frame_start);
    int unsigned w;
    int unsigned h;
    logic [15:0] above;
    logic [19:0] c_idx;
    bit          left_tri;
    bit          above_tri;
    tri_t        t;
    w = clamp_size(width_reg, MAX_W);
    h = clamp_size(height_reg, MAX_H);
    if (frame_start) begin
      col_pos = 0;
      row_pos = 0;
      lin_idx = '0;
    end
    above = row_above_mem[col_pos];
    if (depth != 16'd0 && col_pos != 0 && row_pos != 0 && depths_close(depth, diag_px)) begin
      c_idx     = lin_idx;
      left_tri  = depths_close(depth, left_px) && depths_close(left_px, diag_px);
      above_tri = depths_close(depth, above) && depths_close(above, diag_px);
      t.centre  = c_idx;
      t.diag    = c_idx - 20'(w) - 20'd1;
      if (left_tri) begin
        t.first = c_idx - 20'd1;
        t.kind  = KIND_LEFT;
        t.last  = !above_tri;
        expected_tris.push_back(t);
      end
      if (above_tri) begin
        t.first = c_idx - 20'(w);
        t.kind  = KIND_ABOVE;
        t.last  = 1'b1;
        expected_tris.push_back(t);
      end
    end
    row_above_mem[col_pos] = depth;
    diag_px = above;
    left_px = depth;
    col_pos++;
    lin_idx = lin_idx + 20'd1;
    // a shrunk width ends the row as soon as the column reaches it
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) begin
        row_pos = 0;
        lin_idx = '0;
      end
    end
  endtask

  // source side: present the oldest pending word, predict on acceptance
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
      src_gap = 0;
    end else begin
      if (s_tvalid && s_tready) begin
        triangulate_pixel(s_tdata, s_tuser[0]);
        void'(pending_pixels.pop_front());
        src_gap = (src_idle_on && $urandom_range(0, 1) == 0) ? idle_length() : 0;
      end
      if (src_gap != 0) begin
        src_gap--;
        s_tvalid <= 1'b0;
      end else if (pending_pixels.size() != 0) begin
        s_tvalid <= 1'b1;
        s_tdata  <= pending_pixels[0].depth;
        s_tuser  <= pending_pixels[0].frame_start;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // result side: random back-pressure, every accepted word checked in order
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      sink_stall = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_tris.size() == 0) begin
          report_bad($sformatf("unexpected word %h kind %0d last %0d",
                               m_tdata, m_tuser, m_tlast));
        end else begin
          tri_t want;
          want = expected_tris.pop_front();
          if (m_tdata[19:0] !== want.first)
            report_bad($sformatf("first corner %0d, want %0d", m_tdata[19:0], want.first));
          if (m_tdata[39:20] !== want.centre)
            report_bad($sformatf("centre %0d, want %0d", m_tdata[39:20], want.centre));
          if (m_tdata[59:40] !== want.diag)
            report_bad($sformatf("diagonal %0d, want %0d", m_tdata[59:40], want.diag));
          if (m_tdata[63:60] !== 4'd0)
            report_bad($sformatf("padding bits %h not zero", m_tdata[63:60]));
          if (m_tuser[0] !== want.kind)
            report_bad($sformatf("kind %b, want %b (centre %0d)", m_tuser[0], want.kind,
                                 want.centre));
          if (m_tlast !== want.last)
            report_bad($sformatf("last %b, want %b (centre %0d)", m_tlast, want.last,
                                 want.centre));
        end
      end
      if (sink_stall != 0) begin
        sink_stall--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (sink_idle_on && $urandom_range(0, 5) == 0) sink_stall = idle_length();
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("depth_grid_triangulator: mismatch");
      $finish;
    end
  end

  // register write, only ever issued while the block is idle
  task automatic write_reg(input logic [1:0] index, input logic [15:0] value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (index)
      CFG_THRESHOLD: thr_reg = value;
      CFG_WIDTH: width_reg = value[10:0];
      CFG_HEIGHT: height_reg = value[10:0];
      default: ;
    endcase
  endtask

  // size registers hold 11 bits; junk above them must be dropped
  task automatic write_sizes(input logic [10:0] w, input logic [10:0] h);
    write_reg(CFG_WIDTH, {5'($urandom), w});
    write_reg(CFG_HEIGHT, {5'($urandom), h});
  endtask

  // queue a run of pixels drifting around one base depth
  task automatic queue_pixels(input int unsigned count, input bit start_frame,
                              input int unsigned spread);
    logic [15:0] base;
    pixel_word_t px;
    base = ($urandom_range(0, 7) == 0) ? 16'(65535 - $urandom_range(0, 64))
                                       : 16'($urandom);
    for (int unsigned i = 0; i < count; i++) begin
      px.depth       = smooth_depth(base, spread);
      px.frame_start = (i == 0 && start_frame) || ($urandom_range(0, 299) == 0);
      pending_pixels.push_back(px);
    end
  endtask

  // wait until every word is taken and every triangle has come out
  task automatic drain();
    while (pending_pixels.size() != 0 || s_tvalid || expected_tris.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned random_pixels;
    int unsigned n;
    int unsigned spread;
    logic [15:0] thr;
    logic [10:0] w;
    logic [10:0] h;
    pixel_word_t px;

    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset registers as they are: threshold 5 over a 640-wide frame, into row 1
    src_idle_on  = 1'b1;
    sink_idle_on = 1'b1;
    queue_pixels(660, 1'b1, 3);
    drain();

    // directed frame, no idling so pixels run back to back
    src_idle_on  = 1'b0;
    sink_idle_on = 1'b0;
    write_reg(CFG_THRESHOLD, 16'd10);
    write_sizes(11'd4, 11'd3);
    foreach (DIRECTED_DEPTHS[i]) begin
      px.depth       = DIRECTED_DEPTHS[i];
      px.frame_start = (i == 0 || i == 16);
      pending_pixels.push_back(px);
    end
    drain();

    // zero threshold: nothing can pass
    src_idle_on = 1'b1;
    write_reg(CFG_THRESHOLD, 16'd0);
    write_sizes(11'd3, 11'd2);
    queue_pixels(20, 1'b1, 2);
    drain();

    // full threshold with sizes under the minimum, clamped to 2 x 2
    sink_idle_on = 1'b1;
    write_reg(CFG_THRESHOLD, 16'hFFFF);
    write_sizes(11'd0, 11'd1);
    queue_pixels(20, 1'b1, 40000);
    drain();

    // sizes over the maximum, carried on mid-frame
    write_sizes(11'd2047, 11'd2047);
    queue_pixels(40, 1'b0, 3000);
    drain();

    // random phases: new registers each time, mostly well-formed frames
    random_pixels = 0;
    while (random_pixels < RANDOM_PIXELS) begin
      case ($urandom_range(0, 9))
        0: thr = 16'd0;
        1: thr = 16'hFFFF;
        2: thr = 16'd1;
        default: thr = 16'($urandom_range(2, 40));
      endcase
      case ($urandom_range(0, 15))
        0: w = 11'd0;
        1: w = 11'd1;
        2: w = 11'd2047;
        3: w = 11'd1025;
        default: w = 11'($urandom_range(2, 12));
      endcase
      case ($urandom_range(0, 15))
        0: h = 11'd0;
        1: h = 11'd1;
        2: h = 11'd2047;
        default: h = 11'($urandom_range(2, 6));
      endcase
      write_reg(CFG_THRESHOLD, thr);
      write_sizes(w, h);
      // about two thirds of the phases keep a tight spread so both triangles show up
      if (thr < 16'd2) spread = 3;
      else if ($urandom_range(0, 2) == 0) spread = int'(thr) * 2;
      else spread = int'(thr) / 2;
      src_idle_on  = ($urandom_range(0, 3) != 0);
      sink_idle_on = ($urandom_range(0, 3) != 0);
      n = $urandom_range(40, 110);
      // a phase without a frame start keeps counting under the new sizes;
      // a wide phase always starts one so it stays in the filled part of the line store
      queue_pixels(n, ($urandom_range(0, 3) != 0) || (w > 11'd12), spread);
      random_pixels += n;
      drain();
    end

    if (bad_count == 0) begin
      $display("depth_grid_triangulator: match");
    end else begin
      $display("depth_grid_triangulator: mismatch");
    end
    $finish;
  end

endmodule
